@@ rtl/acrh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package acrh_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_WORDS  = 12;
    localparam int IDX_W      = 4;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 1;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_SECOND = 1'b1;

    localparam logic [63:0] NONCE_FIRST_RST  = 64'habbaabbaabbaabba;
    localparam logic [63:0] NONCE_SECOND_RST = 64'h5aa55aa55aa55aa5;

    localparam logic [31:0] IV0 = 32'h94fe680b;
    localparam logic [31:0] IV1 = 32'hd2277859;
    localparam logic [31:0] IV2 = 32'hd59c944b;
    localparam logic [31:0] IV3 = 32'hc6b2041b;
    localparam logic [31:0] IV4 = 32'he13d4527;
    localparam logic [31:0] IV5 = 32'hf6b9d3dd;
    localparam logic [31:0] IV6 = 32'h45afd531;
    localparam logic [31:0] IV7 = 32'h7ddb19e5;

    localparam logic [3:0] BASE_ITERS = 4'd10;
    localparam logic [1:0] ITER_MASK  = 2'h3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } cmd_t;

    function automatic logic [31:0] add_eac(input logic [31:0] x, input logic [31:0] y);
        logic [32:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[31:0] + {31'b0, s[32]};
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        return (v << s) | (v >> (6'd32 - {1'b0, s}));
    endfunction

endpackage

`default_nettype wire

@@ rtl/acrh_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acrh_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [1:0]    kind,
    input  wire logic [7:0]    data_byte,
    output logic               full,
    output logic               cmd_valid,
    output acrh_pkg::cmd_t     cmd,
    input  wire logic          cmd_pop
);

    acrh_pkg::cmd_t                    mem_reg [acrh_pkg::FIFO_DEPTH];
    logic [acrh_pkg::PTR_W-1:0]        wr_ptr_reg;
    logic [acrh_pkg::PTR_W-1:0]        wr_ptr_next;
    logic [acrh_pkg::PTR_W-1:0]        rd_ptr_reg;
    logic [acrh_pkg::PTR_W-1:0]        rd_ptr_next;
    logic [acrh_pkg::CNT_W-1:0]        count_reg;
    logic [acrh_pkg::CNT_W-1:0]        count_next;
    logic                              store;
    logic                              take;

    assign full      = (count_reg == acrh_pkg::CNT_W'(acrh_pkg::FIFO_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = mem_reg[rd_ptr_reg];

    // unused kind is taken and dropped
    assign store = push && !full && (kind != acrh_pkg::KIND_UNUSED);
    assign take  = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = store ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + acrh_pkg::CNT_W'(store) - acrh_pkg::CNT_W'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            mem_reg[wr_ptr_reg] <= '{kind: kind, data_byte: data_byte};
        end
    end

endmodule

`default_nettype wire

@@ rtl/acrh_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acrh_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire acrh_pkg::cmd_t cmd,
    output logic               cmd_pop,
    input  wire logic [63:0]   nonce_first,
    input  wire logic [63:0]   nonce_second,
    output logic               out_valid,
    output logic [63:0]        out_high,
    output logic [63:0]        out_low,
    input  wire logic          out_pop
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LEN  = 3'd1;
    localparam logic [2:0] S_MIX0 = 3'd2;
    localparam logic [2:0] S_MIX1 = 3'd3;
    localparam logic [2:0] S_FOLD = 3'd4;

    // words 0..3 block, 4..11 chain
    logic [31:0] v_reg [acrh_pkg::NUM_WORDS];
    logic [31:0] v_next [acrh_pkg::NUM_WORDS];
    logic [2:0]  state_reg,    state_next;
    logic [3:0]  fill_reg,     fill_next;
    logic [63:0] len_reg,      len_next;
    logic [63:0] len_lat_reg,  len_lat_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic        fin_reg,      fin_next;
    logic [2:0]  call_reg,     call_next;
    logic [3:0]  iter_reg,     iter_next;
    logic [3:0]  limit_reg,    limit_next;
    logic [31:0] ta_reg, ta_next, tb_reg, tb_next, tc_reg, tc_next, td_reg, td_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_high_reg, out_high_next;
    logic [63:0] out_low_reg,  out_low_next;

    logic [acrh_pkg::IDX_W-1:0] idx_a, idx_b, idx_c, idx_d;
    logic [31:0] qa, qb, qc, qd;
    logic [31:0] a1, b1, c1, d1;
    logic [31:0] a2, b2, c2, d2;
    logic [31:0] f0, f1, f2, f3;
    logic [3:0]  fill_inc;
    logic        fill_wrap;
    logic        absorb_en;
    logic [7:0]  absorb_val;
    logic [2:0]  len_k;
    logic        mix_last;

    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid;
    assign out_valid = out_valid_reg;
    assign out_high  = out_high_reg;
    assign out_low   = out_low_reg;

    assign fill_inc  = fill_reg + 4'd1;
    assign fill_wrap = (fill_inc == 4'd0);
    assign len_k     = 3'(len_left_reg - 4'd1);
    assign mix_last  = (call_reg == 3'd7) && (iter_reg == limit_reg - 4'd1);

    // operand select for the current round call
    always_comb
    begin
        unique case (call_reg)
            3'd0:    {idx_a, idx_b, idx_c, idx_d} = {4'd0, 4'd4,  4'd1,  4'd6};
            3'd1:    {idx_a, idx_b, idx_c, idx_d} = {4'd2, 4'd8,  4'd3,  4'd10};
            3'd2:    {idx_a, idx_b, idx_c, idx_d} = {4'd0, 4'd5,  4'd1,  4'd7};
            3'd3:    {idx_a, idx_b, idx_c, idx_d} = {4'd2, 4'd9,  4'd3,  4'd11};
            3'd4:    {idx_a, idx_b, idx_c, idx_d} = {4'd4, 4'd8,  4'd5,  4'd9};
            3'd5:    {idx_a, idx_b, idx_c, idx_d} = {4'd6, 4'd10, 4'd7,  4'd11};
            3'd6:    {idx_a, idx_b, idx_c, idx_d} = {4'd4, 4'd5,  4'd6,  4'd7};
            default: {idx_a, idx_b, idx_c, idx_d} = {4'd8, 4'd9,  4'd10, 4'd11};
        endcase
    end

    assign qa = v_reg[idx_a];
    assign qb = v_reg[idx_b];
    assign qc = v_reg[idx_c];
    assign qd = v_reg[idx_d];

    // first half of a round call
    always_comb
    begin
        a1 = acrh_pkg::add_eac(qa, qd ^ 32'd5);
        b1 = acrh_pkg::add_eac(qb, qc ^ 32'd11);
        c1 = acrh_pkg::add_eac(qc, qd ^ 32'd17);
        d1 = acrh_pkg::add_eac(qd, c1 ^ 32'd23);
    end

    // second half of a round call
    always_comb
    begin
        b2 = acrh_pkg::rotl32(acrh_pkg::add_eac(tb_reg, tc_reg), 5'd29);
        c2 = acrh_pkg::rotl32(acrh_pkg::add_eac(tc_reg, td_reg), 5'd19);
        d2 = acrh_pkg::rotl32(acrh_pkg::add_eac(td_reg, ta_reg), 5'd13);
        a2 = acrh_pkg::rotl32(acrh_pkg::add_eac(ta_reg, d2), 5'd7);
    end

    // final fold of chain words
    always_comb
    begin
        f0 = acrh_pkg::add_eac(v_reg[4], acrh_pkg::rotl32(v_reg[11], 5'd11));
        f1 = acrh_pkg::add_eac(v_reg[5], acrh_pkg::rotl32(v_reg[10], 5'd19));
        f2 = acrh_pkg::add_eac(v_reg[6], acrh_pkg::rotl32(v_reg[9], 5'd17));
        f3 = acrh_pkg::add_eac(v_reg[7], acrh_pkg::rotl32(v_reg[8], 5'd9));
    end

    always_comb
    begin
        v_next         = v_reg;
        state_next     = state_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        len_lat_next   = len_lat_reg;
        len_left_next  = len_left_reg;
        fin_next       = fin_reg;
        call_next      = call_reg;
        iter_next      = iter_reg;
        limit_next     = limit_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        tc_next        = tc_reg;
        td_next        = td_reg;
        out_valid_next = out_valid_reg && !out_pop;
        out_high_next  = out_high_reg;
        out_low_next   = out_low_reg;
        absorb_en      = 1'b0;
        absorb_val     = cmd.data_byte;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        acrh_pkg::KIND_START:
                        begin
                            v_next[0]  = '0;
                            v_next[1]  = '0;
                            v_next[2]  = '0;
                            v_next[3]  = '0;
                            v_next[4]  = acrh_pkg::IV0;
                            v_next[5]  = acrh_pkg::IV1 ^ nonce_first[63:32];
                            v_next[6]  = acrh_pkg::IV2;
                            v_next[7]  = acrh_pkg::IV3 ^ nonce_first[31:0];
                            v_next[8]  = acrh_pkg::IV4;
                            v_next[9]  = acrh_pkg::IV5 ^ nonce_second[63:32];
                            v_next[10] = acrh_pkg::IV6;
                            v_next[11] = acrh_pkg::IV7 ^ nonce_second[31:0];
                            fill_next  = '0;
                            len_next   = '0;
                        end
                        acrh_pkg::KIND_DATA:
                        begin
                            absorb_en = 1'b1;
                            if (fill_wrap)
                            begin
                                state_next = S_MIX0;
                            end
                        end
                        acrh_pkg::KIND_FINISH:
                        begin
                            len_lat_next  = len_reg;
                            len_left_next = 4'd8;
                            fin_next      = 1'b1;
                            state_next    = S_LEN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LEN:
            begin
                absorb_en     = 1'b1;
                absorb_val    = len_lat_reg[{len_k, 3'b000} +: 8];
                len_left_next = len_left_reg - 4'd1;
                if (fill_wrap || (len_left_reg == 4'd1))
                begin
                    state_next = S_MIX0;
                end
            end
            S_MIX0:
            begin
                ta_next    = a1;
                tb_next    = b1;
                tc_next    = c1;
                td_next    = d1;
                state_next = S_MIX1;
            end
            S_MIX1:
            begin
                v_next[idx_a] = a2;
                v_next[idx_b] = b2;
                v_next[idx_c] = c2;
                v_next[idx_d] = d2;
                call_next = call_reg + 3'd1;
                if (call_reg == 3'd7)
                begin
                    iter_next = iter_reg + 4'd1;
                end
                if (mix_last)
                begin
                    if (fin_reg && (len_left_reg != 4'd0))
                    begin
                        state_next = S_LEN;
                    end
                    else if (fin_reg)
                    begin
                        state_next = S_FOLD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_MIX0;
                end
            end
            S_FOLD:
            begin
                if (!out_valid_reg || out_pop)
                begin
                    v_next[4]      = f0;
                    v_next[5]      = f1;
                    v_next[6]      = f2;
                    v_next[7]      = f3;
                    out_high_next  = {f0, f1};
                    out_low_next   = {f2, f3};
                    out_valid_next = 1'b1;
                    fin_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (absorb_en)
        begin
            v_next[{2'b00, fill_reg[3:2]}][{fill_reg[1:0], 3'b000} +: 8] = absorb_val;
            fill_next  = fill_inc;
            len_next   = len_reg + 64'd1;
        end

        // iteration count taken from chain word 8 on entry
        if ((state_next == S_MIX0) && (state_reg != S_MIX1))
        begin
            call_next  = '0;
            iter_next  = '0;
            limit_next = acrh_pkg::BASE_ITERS + {2'b00, v_reg[8][1:0] & acrh_pkg::ITER_MASK};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0]      <= '0;
            v_reg[1]      <= '0;
            v_reg[2]      <= '0;
            v_reg[3]      <= '0;
            v_reg[4]      <= acrh_pkg::IV0;
            v_reg[5]      <= acrh_pkg::IV1 ^ acrh_pkg::NONCE_FIRST_RST[63:32];
            v_reg[6]      <= acrh_pkg::IV2;
            v_reg[7]      <= acrh_pkg::IV3 ^ acrh_pkg::NONCE_FIRST_RST[31:0];
            v_reg[8]      <= acrh_pkg::IV4;
            v_reg[9]      <= acrh_pkg::IV5 ^ acrh_pkg::NONCE_SECOND_RST[63:32];
            v_reg[10]     <= acrh_pkg::IV6;
            v_reg[11]     <= acrh_pkg::IV7 ^ acrh_pkg::NONCE_SECOND_RST[31:0];
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            len_left_reg  <= '0;
            fin_reg       <= 1'b0;
            call_reg      <= '0;
            iter_reg      <= '0;
            limit_reg     <= acrh_pkg::BASE_ITERS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v_reg         <= v_next;
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            len_left_reg  <= len_left_next;
            fin_reg       <= fin_next;
            call_reg      <= call_next;
            iter_reg      <= iter_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_lat_reg  <= len_lat_next;
        ta_reg       <= ta_next;
        tb_reg       <= tb_next;
        tc_reg       <= tc_next;
        td_reg       <= td_next;
        out_high_reg <= out_high_next;
        out_low_reg  <= out_low_next;
    end

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX0 || state_reg == S_MIX1) |-> (iter_reg < limit_reg))
        else $error("mix iteration past limit");

    a_out_from_fold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FOLD))
        else $error("digest word without fold");

    a_len_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEN) |-> (fin_reg && len_left_reg != 4'd0))
        else $error("length byte out of finish");

    a_fold_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FOLD) |-> fin_reg && (len_left_reg == 4'd0))
        else $error("fold before length bytes done");

endmodule

`default_nettype wire

@@ rtl/add_carry_rotate_hash_128.sv @@
// 128-bit add-with-end-around-carry / rotate hash over a byte stream. Items enter a
// four-deep command queue, so push is taken whenever full is low; a word of kind 3 is
// taken and dropped. The engine takes a start or data word from the queue only while
// idle; the sixteenth byte of a block starts a compression of 10 to 13 iterations of
// eight round calls, each split into two halves (S_MIX0, S_MIX1). A finish word
// absorbs the eight length bytes, runs up to two compressions and one fold, then
// the digest waits in an output register until popped; the fold holds while an
// earlier digest is unpopped. The nonce registers take effect at the next start word.
`timescale 1ns / 1ps
`default_nettype none

module add_carry_rotate_hash_128 (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [1:0]                         kind,
    input  wire logic [7:0]                         data_byte,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [63:0]                             digest_high,
    output logic [63:0]                             digest_low,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [acrh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [63:0]                        cfg_data
);

    logic [63:0]     nonce_first_reg,  nonce_first_next;
    logic [63:0]     nonce_second_reg, nonce_second_next;
    logic            cmd_valid;
    logic            cmd_pop;
    acrh_pkg::cmd_t  cmd;
    logic            out_valid;

    assign cfg_ready = 1'b1;
    assign empty     = !out_valid;

    always_comb
    begin
        nonce_first_next  = nonce_first_reg;
        nonce_second_next = nonce_second_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                acrh_pkg::CFG_NONCE_FIRST:  nonce_first_next  = cfg_data;
                acrh_pkg::CFG_NONCE_SECOND: nonce_second_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonce_first_reg  <= acrh_pkg::NONCE_FIRST_RST;
            nonce_second_reg <= acrh_pkg::NONCE_SECOND_RST;
        end
        else
        begin
            nonce_first_reg  <= nonce_first_next;
            nonce_second_reg <= nonce_second_next;
        end
    end

    acrh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .kind      (kind),
        .data_byte (data_byte),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    acrh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .nonce_first  (nonce_first_reg),
        .nonce_second (nonce_second_reg),
        .out_valid    (out_valid),
        .out_high     (digest_high),
        .out_low      (digest_low),
        .out_pop      (pop)
    );

endmodule

`default_nettype wire

@@ tb/sv/add_carry_rotate_hash_128_tb.sv @@
`timescale 1ns / 1ps

module add_carry_rotate_hash_128_tb;

    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 2000;
    localparam int LONG_HOLD_CYCLES = 1500;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int CH = 4;
    localparam logic [63:0] FIRST_NONCE_RST = 64'habbaabbaabbaabba;
    localparam logic [63:0] SECOND_NONCE_RST = 64'h5aa55aa55aa55aa5;

    typedef struct packed {
        logic [63:0] upper;
        logic [63:0] lower;
    } digest_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [1:0] kind = acrh_pkg::KIND_START;
    logic [7:0] data_byte = 8'h00;
    logic empty;
    logic pop = 1'b0;
    logic [63:0] digest_high;
    logic [63:0] digest_low;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [acrh_pkg::CFG_IDX_W-1:0] cfg_index = acrh_pkg::CFG_NONCE_FIRST;
    logic [63:0] cfg_data = 64'h0;

    // words 0..3 hold the message block, words 4..11 the chain
    logic [31:0] hash_words [12];
    logic [3:0] block_fill;
    logic [63:0] byte_count;
    logic [63:0] nonce_first_q;
    logic [63:0] nonce_second_q;

    acrh_pkg::cmd_t pending_cmds [$];
    digest_t expected_digests [$];
    int queued_items = 0;
    int mismatches = 0;
    int cycles = 0;
    bit quiet_tail = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int send_gap = 0;
    int recv_stall = 0;
    int long_hold = 0;

    add_carry_rotate_hash_128 DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .kind(kind),
        .data_byte(data_byte),
        .empty(empty),
        .pop(pop),
        .digest_high(digest_high),
        .digest_low(digest_low),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic [31:0] eac_add(input logic [31:0] x, input logic [31:0] y);
        logic [32:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[31:0] + {31'b0, s[32]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic quad_mix(input int p, input int q, input int r, input int s);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        a = hash_words[p];
        b = hash_words[q];
        c = hash_words[r];
        d = hash_words[s];
        a = eac_add(a, d ^ 32'd5);
        b = eac_add(b, c ^ 32'd11);
        c = eac_add(c, d ^ 32'd17);
        d = eac_add(d, c ^ 32'd23);
        b = rotl(eac_add(b, c), 29);
        c = rotl(eac_add(c, d), 19);
        d = rotl(eac_add(d, a), 13);
        a = rotl(eac_add(a, d), 7);
        hash_words[p] = a;
        hash_words[q] = b;
        hash_words[r] = c;
        hash_words[s] = d;
    endtask

    task automatic compress_block();
        int rounds;
        rounds = 10 + int'(hash_words[CH + 4][1:0]);
        for (int i = 0; i < rounds; i++)
        begin
            quad_mix(0, CH + 0, 1, CH + 2);
            quad_mix(2, CH + 4, 3, CH + 6);
            quad_mix(0, CH + 1, 1, CH + 3);
            quad_mix(2, CH + 5, 3, CH + 7);
            quad_mix(CH + 0, CH + 4, CH + 1, CH + 5);
            quad_mix(CH + 2, CH + 6, CH + 3, CH + 7);
            quad_mix(CH + 0, CH + 1, CH + 2, CH + 3);
            quad_mix(CH + 4, CH + 5, CH + 6, CH + 7);
        end
    endtask

    task automatic absorb(input logic [7:0] b);
        hash_words[block_fill[3:2]][8 * block_fill[1:0] +: 8] = b;
        byte_count = byte_count + 64'd1;
        block_fill = block_fill + 4'd1;
        if (block_fill == 4'd0)
            compress_block();
    endtask

    task automatic begin_message();
        hash_words[CH + 0] = 32'h94fe680b;
        hash_words[CH + 1] = 32'hd2277859 ^ nonce_first_q[63:32];
        hash_words[CH + 2] = 32'hd59c944b;
        hash_words[CH + 3] = 32'hc6b2041b ^ nonce_first_q[31:0];
        hash_words[CH + 4] = 32'he13d4527;
        hash_words[CH + 5] = 32'hf6b9d3dd ^ nonce_second_q[63:32];
        hash_words[CH + 6] = 32'h45afd531;
        hash_words[CH + 7] = 32'h7ddb19e5 ^ nonce_second_q[31:0];
        for (int i = 0; i < 4; i++)
            hash_words[i] = 32'h0;
        block_fill = 4'd0;
        byte_count = 64'd0;
    endtask

    task automatic predict_digest(input logic [1:0] k, input logic [7:0] b);
        logic [63:0] len;
        digest_t d;
        if (k == acrh_pkg::KIND_START)
            begin_message();
        else if (k == acrh_pkg::KIND_DATA)
            absorb(b);
        else if (k == acrh_pkg::KIND_FINISH)
        begin
            len = byte_count;
            for (int i = 7; i >= 0; i--)
                absorb(len[8 * i +: 8]);
            if (block_fill != 4'd0)
                compress_block();
            hash_words[CH + 0] = eac_add(hash_words[CH + 0], rotl(hash_words[CH + 7], 11));
            hash_words[CH + 1] = eac_add(hash_words[CH + 1], rotl(hash_words[CH + 6], 19));
            hash_words[CH + 2] = eac_add(hash_words[CH + 2], rotl(hash_words[CH + 5], 17));
            hash_words[CH + 3] = eac_add(hash_words[CH + 3], rotl(hash_words[CH + 4], 9));
            d.upper = {hash_words[CH + 0], hash_words[CH + 1]};
            d.lower = {hash_words[CH + 2], hash_words[CH + 3]};
            expected_digests.push_back(d);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic queue_cmd(input logic [1:0] k, input logic [7:0] b);
        acrh_pkg::cmd_t c;
        c.kind = k;
        c.data_byte = b;
        pending_cmds.push_back(c);
        if (k != acrh_pkg::KIND_UNUSED)
            queued_items++;
    endtask

    task automatic queue_bytes(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 31) == 0)
                queue_cmd(acrh_pkg::KIND_UNUSED, 8'($urandom_range(0, 255)));
            queue_cmd(acrh_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic queue_messages(input int target, input bit short_msgs);
        int goal;
        int pick;
        int len;
        goal = queued_items + target;
        while (queued_items < goal)
        begin
            pick = $urandom_range(0, 99);
            if (short_msgs)
                len = $urandom_range(0, 3);
            else if (pick < 60)
                len = $urandom_range(0, 20);
            else if (pick < 90)
                len = $urandom_range(21, 48);
            else
                len = $urandom_range(49, 96);
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                queue_cmd(acrh_pkg::KIND_START, 8'($urandom_range(0, 255)));
                queue_bytes(len);
                queue_cmd(acrh_pkg::KIND_FINISH, 8'($urandom_range(0, 255)));
            end
            else if (pick < 89)
            begin
                queue_bytes(len);
                queue_cmd(acrh_pkg::KIND_FINISH, 8'($urandom_range(0, 255)));
            end
            else if (pick < 93)
            begin
                queue_cmd(acrh_pkg::KIND_START, 8'($urandom_range(0, 255)));
                queue_bytes(len);
                queue_cmd(acrh_pkg::KIND_FINISH, 8'($urandom_range(0, 255)));
                queue_cmd(acrh_pkg::KIND_FINISH, 8'($urandom_range(0, 255)));
            end
            else if (pick < 96)
            begin
                queue_cmd(acrh_pkg::KIND_START, 8'($urandom_range(0, 255)));
                queue_bytes(len);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    queue_cmd(acrh_pkg::KIND_UNUSED, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic write_nonce(input logic [acrh_pkg::CFG_IDX_W-1:0] idx,
                               input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == acrh_pkg::CFG_NONCE_FIRST)
            nonce_first_q = value;
        else
            nonce_second_q = value;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || push || expected_digests.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : drive_proc
        logic next_push;
        acrh_pkg::cmd_t c;
        next_push = push;
        if (!rst_n)
            next_push = 1'b0;
        else
        begin
            if (push && !full)
            begin
                predict_digest(kind, data_byte);
                next_push = 1'b0;
            end
            if (!next_push)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (!quiet_tail && $urandom_range(0, 11) == 0)
                    send_gap = $urandom_range(0, 15);
                else if (pending_cmds.size() != 0)
                begin
                    c = pending_cmds.pop_front();
                    kind <= c.kind;
                    data_byte <= c.data_byte;
                    next_push = 1'b1;
                end
            end
        end
        push <= next_push;
    end

    always @(posedge clk)
    begin : result_proc
        logic next_pop;
        digest_t want;
        next_pop = pop;
        if (!rst_n)
            next_pop = 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_digests.size() == 0)
                    report_mismatch("unexpected digest_high", digest_high, 64'h0);
                else
                begin
                    want = expected_digests.pop_front();
                    if (digest_high !== want.upper)
                        report_mismatch("digest_high", digest_high, want.upper);
                    if (digest_low !== want.lower)
                        report_mismatch("digest_low", digest_low, want.lower);
                end
            end
            if (hold_req && !hold_done)
            begin
                long_hold = LONG_HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                next_pop = 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                next_pop = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                recv_stall = $urandom_range(0, 15);
                next_pop = 1'b0;
            end
            else
                next_pop = 1'b1;
        end
        pop <= next_pop;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        nonce_first_q = FIRST_NONCE_RST;
        nonce_second_q = SECOND_NONCE_RST;
        begin_message();

        // finish and data before any start, unused kind, short and empty messages
        queue_cmd(acrh_pkg::KIND_FINISH, 8'h00);
        queue_cmd(acrh_pkg::KIND_UNUSED, 8'hff);
        queue_cmd(acrh_pkg::KIND_DATA, 8'ha5);
        queue_cmd(acrh_pkg::KIND_FINISH, 8'hff);
        queue_cmd(acrh_pkg::KIND_START, 8'hff);
        queue_cmd(acrh_pkg::KIND_DATA, 8'h00);
        queue_cmd(acrh_pkg::KIND_DATA, 8'hff);
        queue_cmd(acrh_pkg::KIND_UNUSED, 8'h00);
        queue_cmd(acrh_pkg::KIND_FINISH, 8'h00);
        queue_cmd(acrh_pkg::KIND_START, 8'h00);
        queue_cmd(acrh_pkg::KIND_DATA, 8'h01);
        queue_cmd(acrh_pkg::KIND_DATA, 8'h80);
        queue_cmd(acrh_pkg::KIND_DATA, 8'h7f);
        queue_cmd(acrh_pkg::KIND_DATA, 8'hfe);
        queue_cmd(acrh_pkg::KIND_DATA, 8'h55);
        queue_cmd(acrh_pkg::KIND_DATA, 8'haa);
        queue_cmd(acrh_pkg::KIND_DATA, 8'h0f);
        queue_cmd(acrh_pkg::KIND_DATA, 8'hf0);
        queue_cmd(acrh_pkg::KIND_FINISH, 8'h00);
        queue_cmd(acrh_pkg::KIND_START, 8'h00);
        queue_cmd(acrh_pkg::KIND_FINISH, 8'h00);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        write_nonce(acrh_pkg::CFG_NONCE_FIRST, 64'h0);
        write_nonce(acrh_pkg::CFG_NONCE_SECOND, 64'h0);
        queue_messages(330, 1'b0);
        wait_drained();

        write_nonce(acrh_pkg::CFG_NONCE_FIRST, 64'hffffffffffffffff);
        write_nonce(acrh_pkg::CFG_NONCE_SECOND, 64'hffffffffffffffff);
        queue_messages(330, 1'b0);
        wait_drained();

        // receiver holds off while short messages keep coming
        write_nonce(acrh_pkg::CFG_NONCE_FIRST, {$urandom, $urandom});
        write_nonce(acrh_pkg::CFG_NONCE_SECOND, {$urandom, $urandom});
        hold_req = 1'b1;
        queue_messages(200, 1'b1);
        wait_drained();

        write_nonce(acrh_pkg::CFG_NONCE_SECOND, 64'h0);
        write_nonce(acrh_pkg::CFG_NONCE_FIRST, {$urandom, $urandom});
        queue_messages(330, 1'b0);
        wait_drained();

        write_nonce(acrh_pkg::CFG_NONCE_FIRST, FIRST_NONCE_RST);
        write_nonce(acrh_pkg::CFG_NONCE_SECOND, {$urandom, $urandom});
        queue_messages(330, 1'b0);
        wait_drained();

        write_nonce(acrh_pkg::CFG_NONCE_FIRST, {$urandom, $urandom});
        write_nonce(acrh_pkg::CFG_NONCE_SECOND, {$urandom, $urandom});
        quiet_tail = 1'b1;
        queue_messages(300, 1'b0);
        wait_drained();

        if (mismatches == 0 && expected_digests.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
